// ===== design/gain_scheduled_pd_tracker_top_macros.svh =====
// assertion macros for the gain scheduled pd tracker
`ifndef GAIN_SCHEDULED_PD_TRACKER_TOP_MACROS_SVH
`define GAIN_SCHEDULED_PD_TRACKER_TOP_MACROS_SVH

// condition holds at every edge outside reset
`define GSPD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

// condition in one cycle implies a condition in the next cycle
`define GSPD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sequence violated");

`endif

// ===== design/gspd_pkg.sv =====
// shared types and constants for the gain scheduled pd tracker
package gspd_pkg;

  localparam int OffsetW = 10;
  localparam int TimeW   = 16;
  localparam int LimitW  = 10;
  localparam int GainW   = 16;
  localparam int CenterW = 16;
  localparam int SideW   = 15;
  localparam int DirW    = 2;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [10:0] ERR_BIAS   = 11'd30;
  localparam logic [16:0] SIDE_BIAS2 = 17'd50;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TIME_FIRST  = 3'd0,
    REG_TIME_SECOND = 3'd1,
    REG_TIME_THIRD  = 3'd2,
    REG_LIMIT_LOW   = 3'd3,
    REG_LIMIT_HIGH  = 3'd4,
    REG_GAIN_EARLY  = 3'd5,
    REG_GAIN_LATE   = 3'd6,
    REG_GAIN_DERIV  = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [TimeW-1:0]  time_first;
    logic [TimeW-1:0]  time_second;
    logic [TimeW-1:0]  time_third;
    logic [LimitW-1:0] limit_low;
    logic [LimitW-1:0] limit_high;
    logic [GainW-1:0]  gain_early;
    logic [GainW-1:0]  gain_late;
    logic [GainW-1:0]  gain_deriv;
  } cfg_t;

  localparam logic [GainW-1:0] GAIN_EARLY_RESET = 16'd2688;
  localparam logic [GainW-1:0] GAIN_DERIV_RESET = 16'd51;

endpackage

// ===== design/gspd_core.sv =====
// four stage datapath: input, error and schedule, products, sum and clamp
`include "gain_scheduled_pd_tracker_top_macros.svh"

module gspd_core (
  input  logic                                clk,
  input  logic                                rst,
  input  gspd_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [gspd_pkg::OffsetW-1:0] cam_offset,
  input  logic [gspd_pkg::TimeW-1:0]          elapsed_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [gspd_pkg::CenterW-1:0] center_drive,
  output logic signed [gspd_pkg::SideW-1:0]   side_drive,
  output logic signed [gspd_pkg::DirW-1:0]    direction
);

  // stage valids and advance terms
  logic s0_valid, s1_valid, s2_valid;
  logic adv0, adv1, adv2, adv3;

  assign adv3 = !out_valid || !out_stall;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;
  assign adv0 = !s0_valid || adv1;
  assign in_stall = !adv0;

  // input register
  logic signed [9:0] s0_offset;
  logic [15:0]       s0_elapsed;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv0) begin
      s0_valid <= in_valid;
    end
    if (adv0 && in_valid) begin
      s0_offset  <= cam_offset;
      s0_elapsed <= elapsed_ms;
    end
  end

  // stage 1: error, delta, direction, schedule
  logic signed [9:0]  prev_err;
  logic signed [1:0]  held_dir;
  logic signed [10:0] off_ext, mag, err_wide, mid_diff, mid_half;
  logic signed [9:0]  err;
  logic signed [1:0]  dir_next;
  logic signed [10:0] delta;
  logic signed [10:0] limit_sel;
  logic [15:0]        gain_sel;
  logic signed [10:0] lim_low_s, lim_high_s;

  always_comb begin
    off_ext  = {s0_offset[9], s0_offset};
    mag      = s0_offset[9] ? -off_ext : off_ext;
    err_wide = mag - $signed(gspd_pkg::ERR_BIAS);
    err      = (s0_offset == '0) ? '0 : err_wide[9:0];
    if (s0_offset == '0) begin
      dir_next = held_dir;
    end else if (s0_offset[9]) begin
      dir_next = -2'sd1;
    end else begin
      dir_next = 2'sd1;
    end
    delta = {err[9], err} - {prev_err[9], prev_err};

    lim_low_s  = $signed({1'b0, cfg.limit_low});
    lim_high_s = $signed({1'b0, cfg.limit_high});
    mid_diff   = lim_high_s - lim_low_s;
    // halve toward zero
    mid_half   = (mid_diff + $signed({10'd0, mid_diff[10]})) >>> 1;
    if (s0_elapsed >= cfg.time_third) begin
      limit_sel = lim_low_s;
      gain_sel  = cfg.gain_late;
    end else if (s0_elapsed >= cfg.time_second) begin
      limit_sel = lim_high_s;
      gain_sel  = cfg.gain_late;
    end else if (s0_elapsed >= cfg.time_first) begin
      limit_sel = mid_half + lim_low_s;
      gain_sel  = cfg.gain_early;
    end else begin
      limit_sel = lim_low_s;
      gain_sel  = cfg.gain_early;
    end
  end

  logic signed [9:0]  s1_err;
  logic signed [10:0] s1_delta;
  logic [15:0]        s1_gain;
  logic signed [10:0] s1_limit;
  logic signed [1:0]  s1_dir;
  logic               s1_load;

  assign s1_load = adv1 && s0_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      prev_err <= '0;
      held_dir <= '0;
    end else begin
      if (adv1) begin
        s1_valid <= s0_valid;
      end
      if (s1_load) begin
        prev_err <= err;
        held_dir <= dir_next;
      end
    end
    if (s1_load) begin
      s1_err   <= err;
      s1_delta <= delta;
      s1_gain  <= gain_sel;
      s1_limit <= limit_sel;
      s1_dir   <= dir_next;
    end
  end

  // stage 2: proportional and derivative products
  logic signed [26:0] prod_p;
  logic signed [27:0] prod_d;

  assign prod_p = $signed({1'b0, s1_gain}) * s1_err;
  assign prod_d = $signed({1'b0, cfg.gain_deriv}) * s1_delta;

  logic signed [26:0] s2_prod_p;
  logic signed [27:0] s2_prod_d;
  logic signed [10:0] s2_limit;
  logic signed [1:0]  s2_dir;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
    if (adv2 && s1_valid) begin
      s2_prod_p <= prod_p;
      s2_prod_d <= prod_d;
      s2_limit  <= s1_limit;
      s2_dir    <= s1_dir;
    end
  end

  // stage 3: sum, scale toward zero, clamp, side drive
  logic signed [28:0] acc, acc_adj;
  logic signed [20:0] ctl;
  logic signed [15:0] center_next;
  logic signed [16:0] side_sum, side_half;

  always_comb begin
    acc     = {{2{s2_prod_p[26]}}, s2_prod_p} + {s2_prod_d[27], s2_prod_d};
    acc_adj = acc + (acc[28] ? 29'sd255 : 29'sd0);
    ctl     = acc_adj[28:8];
    if (ctl > $signed({{10{s2_limit[10]}}, s2_limit})) begin
      center_next = {{5{s2_limit[10]}}, s2_limit};
    end else if (ctl < -21'sd32768) begin
      center_next = -16'sd32768;
    end else begin
      center_next = ctl[15:0];
    end
    side_sum  = {center_next[15], center_next} + $signed(gspd_pkg::SIDE_BIAS2);
    side_half = (side_sum + $signed({16'd0, side_sum[16]})) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv3) begin
      out_valid <= s2_valid;
    end
    if (adv3 && s2_valid) begin
      center_drive <= center_next;
      side_drive   <= side_half[14:0];
      direction    <= s2_dir;
    end
  end

  `GSPD_ASSERT_ALWAYS(a_dir_code, held_dir != -2'sd2)
  `GSPD_ASSERT_NEXT(a_prev_err_hold, !s1_load, $stable(prev_err))
  `GSPD_ASSERT_NEXT(a_s1_keep, s1_valid && !adv2, s1_valid)
  `GSPD_ASSERT_ALWAYS(a_center_ceiling, !out_valid || center_drive <= 16'sd1023)

endmodule

// ===== design/gain_scheduled_pd_tracker_top.sv =====
// Gain scheduled PD tracker: each item (signed camera offset, elapsed ms) yields one result
// (center drive, side drive, held direction). The datapath is a four register pipeline
// (input, error and schedule, products, sum and clamp), and a new item can be accepted
// every cycle; throughput is limited only by out_stall. Gains and speed limits are set
// through the write port, which must be written only while no item is in flight; the
// block itself does not enforce this.
module gain_scheduled_pd_tracker_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [gspd_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [gspd_pkg::CfgDataW-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [gspd_pkg::OffsetW-1:0]  cam_offset,
  input  logic [gspd_pkg::TimeW-1:0]           elapsed_ms,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [gspd_pkg::CenterW-1:0]  center_drive,
  output logic signed [gspd_pkg::SideW-1:0]    side_drive,
  output logic signed [gspd_pkg::DirW-1:0]     direction
);

  gspd_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_first  <= '0;
      cfg.time_second <= '0;
      cfg.time_third  <= '0;
      cfg.limit_low   <= '0;
      cfg.limit_high  <= '0;
      cfg.gain_early  <= gspd_pkg::GAIN_EARLY_RESET;
      cfg.gain_late   <= '0;
      cfg.gain_deriv  <= gspd_pkg::GAIN_DERIV_RESET;
    end else if (cfg_we) begin
      unique case (gspd_pkg::cfg_index_t'(cfg_index))
        gspd_pkg::REG_TIME_FIRST:  cfg.time_first  <= cfg_data;
        gspd_pkg::REG_TIME_SECOND: cfg.time_second <= cfg_data;
        gspd_pkg::REG_TIME_THIRD:  cfg.time_third  <= cfg_data;
        gspd_pkg::REG_LIMIT_LOW:   cfg.limit_low   <= cfg_data[gspd_pkg::LimitW-1:0];
        gspd_pkg::REG_LIMIT_HIGH:  cfg.limit_high  <= cfg_data[gspd_pkg::LimitW-1:0];
        gspd_pkg::REG_GAIN_EARLY:  cfg.gain_early  <= cfg_data;
        gspd_pkg::REG_GAIN_LATE:   cfg.gain_late   <= cfg_data;
        gspd_pkg::REG_GAIN_DERIV:  cfg.gain_deriv  <= cfg_data;
        default: ;
      endcase
    end
  end

  gspd_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cam_offset   (cam_offset),
    .elapsed_ms   (elapsed_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .center_drive (center_drive),
    .side_drive   (side_drive),
    .direction    (direction)
  );

endmodule
